>>> src/rpdc_pkg.sv
// Shared types and constants for the RGB reply parser.
// Every other file of the block refers to this package by scoped names.
package rpdc_pkg;

  // Default for the longest number, in digits.
  localparam int MAX_DIGITS_DEF = 3;

  // Configuration register layout.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_HEADER_SKIP = 1'b0;
  localparam logic REG_LABEL_SKIP  = 1'b1;
  localparam logic [5:0] HEADER_SKIP_RST = 6'd10;
  localparam logic [2:0] LABEL_SKIP_RST  = 3'd2;

  // Character codes and value limits.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [9:0] VALUE_MAX = 10'd999;
  localparam logic [5:0] POS_MAX   = 6'd63;

  // Channel codes, also used for the dominant field.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [5:0] header_skip;
    logic [2:0] label_skip;
  } cfg_t;

  typedef struct packed {
    logic [9:0] red_value;
    logic [9:0] green_value;
    logic [9:0] blue_value;
    logic [1:0] dominant;
    logic       complete;
  } result_t;

endpackage

>>> src/rpdc_cfg.sv
// APB-style register file holding header_skip and label_skip.
// Depends on rpdc_pkg for the register layout and the cfg_t type.
module rpdc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpdc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpdc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rpdc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output rpdc_pkg::cfg_t                  cfg
);

  logic [5:0] header_skip_r;
  logic [2:0] label_skip_r;
  logic       wr_en;
  logic       reg_sel;

  // Registers sit on word addresses; the low byte-offset bits are ignored.
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= rpdc_pkg::HEADER_SKIP_RST;
      label_skip_r  <= rpdc_pkg::LABEL_SKIP_RST;
    end else if (wr_en) begin
      if (reg_sel == rpdc_pkg::REG_HEADER_SKIP) begin
        header_skip_r <= pwdata[5:0];
      end else begin
        label_skip_r <= pwdata[2:0];
      end
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    if (reg_sel == rpdc_pkg::REG_HEADER_SKIP) begin
      prdata[5:0] = header_skip_r;
    end else begin
      prdata[2:0] = label_skip_r;
    end
  end

  assign cfg.header_skip = header_skip_r;
  assign cfg.label_skip  = label_skip_r;

endmodule

>>> src/rpdc_parse.sv
// Frame parser: header skip, three decimal numbers, label skips, and the
// result formed on the last byte. Depends on rpdc_pkg for types and codes.
module rpdc_parse #(
  parameter int MAX_DIGITS = rpdc_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpdc_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic              frame_last,
  output rpdc_pkg::result_t result
);

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam logic [DW-1:0] DIGITS_MAX = DW'(MAX_DIGITS);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NUMBER = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [5:0]    pos_r, pos_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    chan_r, chan_nxt;
  logic [DW-1:0] dcnt_r, dcnt_nxt;
  logic [2:0]    skip_r, skip_nxt;
  logic [9:0]    acc_r, acc_nxt;
  logic [9:0]    red_r, red_nxt;
  logic [9:0]    green_r, green_nxt;

  logic          number_byte;
  logic          is_digit;
  logic [7:0]    digit_raw;
  logic [13:0]   acc_prod;

  // Digit decode and accumulator times ten plus the new digit.
  assign is_digit  = (rx_byte >= rpdc_pkg::CHAR_ZERO) && (rx_byte <= rpdc_pkg::CHAR_NINE);
  assign digit_raw = rx_byte - rpdc_pkg::CHAR_ZERO;
  assign acc_prod  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {10'b0, digit_raw[3:0]};

  // Next state for one byte.
  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    chan_nxt    = chan_r;
    dcnt_nxt    = dcnt_r;
    skip_nxt    = skip_r;
    acc_nxt     = acc_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    number_byte = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        if (pos_r < cfg.header_skip) begin
          if (pos_r != rpdc_pkg::POS_MAX) begin
            pos_nxt = pos_r + 6'd1;
          end
        end else begin
          number_byte = 1'b1;
        end
      end
      PH_NUMBER: begin
        number_byte = 1'b1;
      end
      PH_SKIP: begin
        skip_nxt = skip_r + 3'd1;
        if (skip_nxt >= cfg.label_skip) begin
          phase_nxt = PH_NUMBER;
        end
      end
      default: begin
      end
    endcase

    // A digit within MAX_DIGITS adds to the number; any other byte ends it.
    if (number_byte) begin
      phase_nxt = PH_NUMBER;
      if (is_digit && (dcnt_r < DIGITS_MAX)) begin
        acc_nxt  = (acc_prod > {4'b0, rpdc_pkg::VALUE_MAX}) ? rpdc_pkg::VALUE_MAX
                                                            : acc_prod[9:0];
        dcnt_nxt = dcnt_r + DW'(1);
      end else if (chan_r >= rpdc_pkg::CH_BLUE) begin
        phase_nxt = PH_DONE;
      end else begin
        if (chan_r == rpdc_pkg::CH_RED) begin
          red_nxt = acc_r;
        end else begin
          green_nxt = acc_r;
        end
        chan_nxt  = chan_r + 2'd1;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        skip_nxt  = '0;
        phase_nxt = (cfg.label_skip == 3'd0) ? PH_NUMBER : PH_SKIP;
      end
    end
  end

  // Result from the state after this byte; unreached channels read as zero.
  always_comb begin
    result.red_value   = (chan_nxt > rpdc_pkg::CH_RED) ? red_nxt : acc_nxt;
    result.green_value = (chan_nxt > rpdc_pkg::CH_GREEN) ? green_nxt :
                         (chan_nxt == rpdc_pkg::CH_GREEN) ? acc_nxt : 10'd0;
    result.blue_value  = (chan_nxt >= rpdc_pkg::CH_BLUE) ? acc_nxt : 10'd0;
    if (result.red_value > result.green_value) begin
      result.dominant = (result.red_value > result.blue_value) ? rpdc_pkg::CH_RED
                                                               : rpdc_pkg::CH_BLUE;
    end else begin
      result.dominant = (result.green_value > result.blue_value) ? rpdc_pkg::CH_GREEN
                                                                 : rpdc_pkg::CH_BLUE;
    end
    result.complete = (chan_nxt == rpdc_pkg::CH_BLUE) &&
                      ((phase_nxt == PH_DONE) || (dcnt_nxt != '0));
  end

  // State registers; the last byte of a frame returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      chan_r  <= '0;
      dcnt_r  <= '0;
      skip_r  <= '0;
      acc_r   <= '0;
      red_r   <= '0;
      green_r <= '0;
    end else if (step) begin
      if (frame_last) begin
        pos_r   <= '0;
        phase_r <= PH_HEADER;
        chan_r  <= '0;
        dcnt_r  <= '0;
        skip_r  <= '0;
        acc_r   <= '0;
        red_r   <= '0;
        green_r <= '0;
      end else begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        chan_r  <= chan_nxt;
        dcnt_r  <= dcnt_nxt;
        skip_r  <= skip_nxt;
        acc_r   <= acc_nxt;
        red_r   <= red_nxt;
        green_r <= green_nxt;
      end
    end
  end

endmodule

>>> src/rgb_reply_parser_dominant_color_top.sv
// Top level of the RGB reply parser: input register, parser, result register.
// Depends on rpdc_pkg, rpdc_cfg and rpdc_parse.
//
//   Channel | Ports                               | Beat
//   input   | in_valid, in_stall, in_rx_byte ...  | one frame byte
//   result  | out_valid, out_stall, out_red ...   | values of one frame
//   config  | psel, penable, pwrite, paddr ...    | one register write
//
// One byte is taken every cycle unless in_stall holds it back; the last byte
// of a frame passes the input register, then its result enters the result register.
// Reset is synchronous and active low; it clears the parser and both valids.
// A stalled result only holds back the input when the byte waiting in the
// input register is itself the last byte of the next frame.
module rgb_reply_parser_dominant_color_top #(
  parameter int MAX_DIGITS = rpdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_frame_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [9:0]                      out_red_value,
  output logic [9:0]                      out_green_value,
  output logic [9:0]                      out_blue_value,
  output logic [1:0]                      out_dominant,
  output logic                            out_complete,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpdc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpdc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rpdc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  rpdc_pkg::cfg_t    cfg;
  rpdc_pkg::result_t result;
  rpdc_pkg::result_t res_r;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  logic       advance;
  logic       in_take;

  rpdc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held byte moves on unless it ends a frame and the result slot is blocked.
  assign advance  = in_valid_r && !(in_last_r && out_valid_r && out_stall);
  assign in_stall = in_valid_r && in_last_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
      in_last_r <= in_frame_last;
    end
  end

  rpdc_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (advance),
    .rx_byte    (in_byte_r),
    .frame_last (in_last_r),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_value   = res_r.red_value;
  assign out_green_value = res_r.green_value;
  assign out_blue_value  = res_r.blue_value;
  assign out_dominant    = res_r.dominant;
  assign out_complete    = res_r.complete;

endmodule

>>> src/rpdc_checker.sv
// Port-level checks for the RGB reply parser, bound to its top level.
// Depends on rpdc_pkg for the channel codes.
module rpdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_frame_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_red_value,
  input logic [9:0] out_green_value,
  input logic [9:0] out_blue_value,
  input logic [1:0] out_dominant
);

  // A stalled result beat holds its values.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_value) &&
    $stable(out_green_value) && $stable(out_blue_value) && $stable(out_dominant))
    else $error("stalled result changed");

  // Red wins only when it is strictly above both others.
  a_dom_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_dominant == rpdc_pkg::CH_RED) |->
    (out_red_value > out_green_value) && (out_red_value > out_blue_value))
    else $error("red reported dominant without winning");

  // Green wins only when red does not beat it and it beats blue.
  a_dom_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_dominant == rpdc_pkg::CH_GREEN) |->
    !(out_red_value > out_green_value) && (out_green_value > out_blue_value))
    else $error("green reported dominant without winning");

  // A fresh result follows a last byte taken at the input.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_frame_last, 2))
    else $error("result without a frame end");

endmodule

bind rgb_reply_parser_dominant_color_top rpdc_checker u_rpdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_frame_last   (in_frame_last),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red_value   (out_red_value),
  .out_green_value (out_green_value),
  .out_blue_value  (out_blue_value),
  .out_dominant    (out_dominant)
);
